@@ design/gbt_pkg.sv @@
// ----------------------------------------------------------------------------
// gbt_pkg
// Shared constants, types and register indexes for the Goertzel bin tracker.
// ----------------------------------------------------------------------------
package gbt_pkg;

    // fixed-point formats
    localparam int COEFF_FRAC_BITS = 11;
    localparam int TRIG_FRAC_BITS  = 15;

    // field widths
    localparam int COEFF_W  = 14;
    localparam int TRIG_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int STATE_W  = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_AW   = 2;
    localparam int POWER_W  = 63;

    // coeff * delay_one product, split in two halves for the cross term
    localparam int CD1_W       = COEFF_W + STATE_W;
    localparam int CROSS_SPLIT = CD1_W / 2;
    localparam int CROSS_HI_W  = CD1_W - CROSS_SPLIT;

    // shared multiplier of the back end
    localparam int MUL_A_W = STATE_W + 1;
    localparam int MUL_P_W = MUL_A_W + STATE_W;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // square root: one result bit per step
    localparam int SQRT_STEPS = STATE_W;
    localparam int SQRT_REM_W = STATE_W + 3;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_COEFF = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_COS   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SIN   = 2'd2;

    // input modes
    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff;
        logic signed [TRIG_W-1:0]  cos_term;
        logic signed [TRIG_W-1:0]  sin_term;
    } t_cfg;

    // filter state after one item
    typedef struct packed {
        logic signed [STATE_W-1:0] d1;
        logic signed [STATE_W-1:0] d2;
        logic        [STATE_W-1:0] peak;
    } t_snap;

endpackage

@@ design/gbt_queue.sv @@
// ----------------------------------------------------------------------------
// gbt_queue
// Small first-in first-out queue of state snapshots between front and back.
// ----------------------------------------------------------------------------
module gbt_queue
    import gbt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_snap i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_snap o_data,
    output logic  o_empty
);

    t_snap                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/gbt_front.sv @@
// ----------------------------------------------------------------------------
// gbt_front
// Accepts items, runs the Goertzel recurrence and the peak tracker, and
// queues a snapshot of the updated state for the back end.
// ----------------------------------------------------------------------------
module gbt_front
    import gbt_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic                       i_mode,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [COEFF_W-1:0]  i_coeff,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output t_snap                      o_q_snap
);

    logic signed [STATE_W-1:0] r_delay_one;
    logic signed [STATE_W-1:0] r_delay_two;
    logic        [STATE_W-1:0] r_peak;
    logic signed [STATE_W-1:0] n_delay_one;
    logic signed [STATE_W-1:0] n_delay_two;
    logic        [STATE_W-1:0] n_peak;

    logic signed [CD1_W-1:0]   fb_prod;
    logic signed [CD1_W-1:0]   fb_shift;
    logic signed [STATE_W-1:0] s0;
    logic        [STATE_W-1:0] s0_abs;
    logic                      accept;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    // recurrence: s0 = x + (coeff*d1 >> frac) - d2, wrapped to 32 bits
    assign fb_prod  = CD1_W'(i_coeff) * CD1_W'(r_delay_one);
    assign fb_shift = fb_prod >>> COEFF_FRAC_BITS;
    assign s0       = STATE_W'(i_sample) + fb_shift[STATE_W-1:0] - r_delay_two;
    assign s0_abs   = s0[STATE_W-1] ? (STATE_W'(0) - s0) : s0;

    // next state for a clear or a push
    always_comb begin
        n_delay_one = r_delay_one;
        n_delay_two = r_delay_two;
        n_peak      = r_peak;
        if (accept) begin
            unique case (i_mode)
                MODE_CLEAR: begin
                    n_delay_one = '0;
                    n_delay_two = '0;
                    n_peak      = '0;
                end
                MODE_PUSH: begin
                    n_delay_one = s0;
                    n_delay_two = r_delay_one;
                    n_peak      = (s0_abs > r_peak) ? s0_abs : r_peak;
                end
                default: begin
                    n_delay_one = r_delay_one;
                end
            endcase
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_one <= '0;
            r_delay_two <= '0;
            r_peak      <= '0;
        end else begin
            r_delay_one <= n_delay_one;
            r_delay_two <= n_delay_two;
            r_peak      <= n_peak;
        end
    end

    // snapshot of the updated state goes straight into the queue
    assign o_q_push      = accept;
    assign o_q_snap.d1   = n_delay_one;
    assign o_q_snap.d2   = n_delay_two;
    assign o_q_snap.peak = n_peak;

endmodule

@@ design/gbt_back.sv @@
// ----------------------------------------------------------------------------
// gbt_back
// Computes phasor, power and magnitude from one queued snapshot with a
// shared multiplier and a bit-serial square root, then holds the result
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module gbt_back
    import gbt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_q_empty,
    input  t_snap                     i_q_snap,
    output logic                      o_q_pop,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic signed [STATE_W-1:0] o_phasor_re,
    output logic signed [STATE_W-1:0] o_phasor_im,
    output logic        [POWER_W-1:0] o_power,
    output logic        [STATE_W-1:0] o_magnitude,
    output logic        [STATE_W-1:0] o_peak
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // multiply sequence steps
    localparam logic [4:0] MS_D1SQ   = 5'd0;
    localparam logic [4:0] MS_D2SQ   = 5'd1;
    localparam logic [4:0] MS_CD1    = 5'd2;
    localparam logic [4:0] MS_COS    = 5'd3;
    localparam logic [4:0] MS_SIN    = 5'd4;
    localparam logic [4:0] MS_XLO    = 5'd5;
    localparam logic [4:0] MS_XHI    = 5'd6;
    localparam logic [4:0] MS_XACC   = 5'd7;
    localparam logic [4:0] MS_POWER  = 5'd8;
    localparam logic [4:0] SQRT_LAST = 5'(SQRT_STEPS - 1);

    logic [1:0]                r_state;
    logic [4:0]                r_step;

    // snapshot and intermediate results
    logic signed [STATE_W-1:0] r_d1;
    logic signed [STATE_W-1:0] r_d2;
    logic        [STATE_W-1:0] r_peak;
    logic signed [MUL_P_W-1:0] r_prod;
    logic        [63:0]        r_acc;
    logic        [63:0]        r_cross;
    logic        [CD1_W-1:0]   r_cd1;
    logic signed [STATE_W-1:0] r_re;
    logic signed [STATE_W-1:0] r_im;
    logic        [POWER_W-1:0] r_pow;

    // square root
    logic [63:0]               r_sq_val;
    logic [SQRT_REM_W-1:0]     r_rem;
    logic [STATE_W-1:0]        r_root;

    // output register
    logic                      r_out_valid;
    logic signed [STATE_W-1:0] r_o_re;
    logic signed [STATE_W-1:0] r_o_im;
    logic        [POWER_W-1:0] r_o_pow;
    logic        [STATE_W-1:0] r_o_mag;
    logic        [STATE_W-1:0] r_o_peak;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [STATE_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod_trig;
    logic        [63:0]        cross_shift;
    logic        [63:0]        pow_full;
    logic [SQRT_REM_W-1:0]     rem_shift;
    logic [SQRT_REM_W-1:0]     trial;
    logic                      take;
    logic                      out_free;

    assign o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;
    assign out_free = !r_out_valid || i_pop;

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = MUL_A_W'(r_d1);
        mul_b = r_d2;
        unique case (r_step)
            MS_D1SQ: begin
                mul_a = MUL_A_W'(r_d1);
                mul_b = r_d1;
            end
            MS_D2SQ: begin
                mul_a = MUL_A_W'(r_d2);
                mul_b = r_d2;
            end
            MS_CD1: begin
                mul_a = MUL_A_W'(i_cfg.coeff);
                mul_b = r_d1;
            end
            MS_COS: begin
                mul_a = MUL_A_W'(i_cfg.cos_term);
                mul_b = r_d2;
            end
            MS_SIN: begin
                mul_a = MUL_A_W'(i_cfg.sin_term);
                mul_b = r_d2;
            end
            MS_XLO: begin
                mul_a = MUL_A_W'({1'b0, r_cd1[CROSS_SPLIT-1:0]});
                mul_b = r_d2;
            end
            MS_XHI: begin
                mul_a = MUL_A_W'($signed(r_cd1[CD1_W-1:CROSS_SPLIT]));
                mul_b = r_d2;
            end
            default: begin
                mul_a = MUL_A_W'(r_d1);
                mul_b = r_d2;
            end
        endcase
    end

    assign prod_trig   = r_prod >>> TRIG_FRAC_BITS;
    assign cross_shift = 64'($signed(r_cross) >>> COEFF_FRAC_BITS);
    assign pow_full    = r_acc - cross_shift;

    // one square root step: bring down two bits, try to subtract
    assign rem_shift = {r_rem[SQRT_REM_W-3:0], r_sq_val[63:62]};
    assign trial     = {1'b0, r_root, 2'b01};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= ST_MUL;
                        r_step  <= '0;
                    end
                end
                ST_MUL: begin
                    if (r_step == MS_POWER) begin
                        r_state <= ST_SQRT;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_SQRT: begin
                    if (r_step == SQRT_LAST) begin
                        r_state <= ST_DONE;
                    end
                    r_step <= r_step + 1'b1;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_d1   <= i_q_snap.d1;
            r_d2   <= i_q_snap.d2;
            r_peak <= i_q_snap.peak;
        end
        if (r_state == ST_MUL) begin
            r_prod <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
            unique case (r_step)
                MS_D2SQ:  r_acc   <= r_prod[63:0];
                MS_CD1:   r_acc   <= r_acc + r_prod[63:0];
                MS_COS:   r_cd1   <= r_prod[CD1_W-1:0];
                MS_SIN:   r_re    <= r_d1 - prod_trig[STATE_W-1:0];
                MS_XLO:   r_im    <= prod_trig[STATE_W-1:0];
                MS_XHI:   r_cross <= r_prod[63:0];
                MS_XACC:  r_cross <= r_cross + {r_prod[63-CROSS_SPLIT:0], CROSS_SPLIT'(0)};
                MS_POWER: begin
                    r_pow    <= pow_full[63] ? '0 : pow_full[POWER_W-1:0];
                    r_sq_val <= pow_full[63] ? '0 : pow_full;
                    r_rem    <= '0;
                    r_root   <= '0;
                end
                default: ;
            endcase
        end
        if (r_state == ST_SQRT) begin
            r_sq_val <= r_sq_val << 2;
            if (rem_shift >= trial) begin
                r_rem  <= rem_shift - trial;
                r_root <= {r_root[STATE_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_shift;
                r_root <= {r_root[STATE_W-2:0], 1'b0};
            end
        end
    end

    // output register
    assign take = (r_state == ST_DONE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_re   <= r_re;
            r_o_im   <= r_im;
            r_o_pow  <= r_pow;
            r_o_mag  <= r_root;
            r_o_peak <= r_peak;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_phasor_re = r_o_re;
    assign o_phasor_im = r_o_im;
    assign o_power     = r_o_pow;
    assign o_magnitude = r_o_mag;
    assign o_peak      = r_o_peak;

endmodule

@@ design/goertzel_bin_tracker.sv @@
// ----------------------------------------------------------------------------
// goertzel_bin_tracker
// Fixed-point Goertzel single-bin detector with phasor, power, magnitude
// and peak report for every item.
// ----------------------------------------------------------------------------
//
//  channel   signals                                  transfer when
//  -------   --------------------------------------   ---------------------
//  input     push, full, i_mode, i_sample             push && !full
//  result    empty, pop, o_phasor_re .. o_peak        pop && !empty
//  config    i_cfg_we, i_cfg_addr, i_cfg_data         i_cfg_we
//
//  the front takes one item per cycle unless full and updates the recurrence
//  at once; the back sets the sustained rate, needing per result a load, 9
//  steps on one shared 33x32 multiplier, 32 square root steps and a hand-off.
//  synchronous active-low reset clears the filter state, registers and queue.
//  a waiting result stalls the back end; a four-entry queue lets the front
//  run ahead and full rises only once that queue is full.
//
module goertzel_bin_tracker
    import gbt_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_mode,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [STATE_W-1:0]  o_phasor_re,
    output logic signed [STATE_W-1:0]  o_phasor_im,
    output logic        [POWER_W-1:0]  o_power,
    output logic        [STATE_W-1:0]  o_magnitude,
    output logic        [STATE_W-1:0]  o_peak,
    input  logic                       i_cfg_we,
    input  logic        [CFG_AW-1:0]   i_cfg_addr,
    input  logic        [CFG_W-1:0]    i_cfg_data
);

    t_cfg  r_cfg;
    t_snap q_in;
    t_snap q_out;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_COEFF: r_cfg.coeff    <= i_cfg_data[COEFF_W-1:0];
                CFG_COS:   r_cfg.cos_term <= i_cfg_data[TRIG_W-1:0];
                CFG_SIN:   r_cfg.sin_term <= i_cfg_data[TRIG_W-1:0];
                default:   r_cfg          <= r_cfg;
            endcase
        end
    end

    // recurrence and peak
    gbt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_mode   (i_mode),
        .i_sample (i_sample),
        .i_coeff  (r_cfg.coeff),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_snap (q_in)
    );

    // snapshot queue
    gbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // output computation
    gbt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_q_snap    (q_out),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_phasor_re (o_phasor_re),
        .o_phasor_im (o_phasor_im),
        .o_power     (o_power),
        .o_magnitude (o_magnitude),
        .o_peak      (o_peak)
    );

    // both sides come out of reset ready and empty
    a_reset_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!full && empty))
        else $error("queue not clear after reset");

    // a zero power has a zero root
    a_zero_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_power == '0)) |-> (o_magnitude == '0))
        else $error("nonzero magnitude for zero power");

    // the root never exceeds a nonzero power
    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_power != '0)) |-> (POWER_W'(o_magnitude) <= o_power))
        else $error("magnitude above power");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Goertzel bin tracker. A short table of directed
// items and register writes runs first. A steered ramp then drives the
// recurrence onto its most negative value. Three phases of random clear/push
// bursts follow, each with a different idling pattern on the two queue sides.
// Every result is checked field by field against a pinned value or a bit-true
// model of the recurrence, phasor, power, root and peak.
// ----------------------------------------------------------------------------
module tb_top
    import gbt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 4;
    localparam int PHASE_ITEMS  = 300;

    // index with no register behind it
    localparam logic [CFG_AW-1:0] CFG_UNUSED = 2'd3;

    // steered ramp toward the most negative recurrence value
    localparam longint S0_FLOOR    = 64'shFFFF_FFFF_8000_0000;
    localparam longint RAMP_DECEL  = 32767;
    localparam longint RAMP_ACCEL  = 32768;
    localparam int     RAMP_STEPS  = 4000;

    typedef struct packed {
        logic signed [STATE_W-1:0] re;
        logic signed [STATE_W-1:0] im;
        logic        [POWER_W-1:0] power;
        logic        [STATE_W-1:0] mag;
        logic        [STATE_W-1:0] peak;
    } bin_report_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CFG
    } row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [CFG_AW-1:0]  addr;
        logic               mode;
        logic [CFG_W-1:0]   value;
        logic               pinned;
        bin_report_t        want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 30;

    // dut ports
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       push        = 1'b0;
    logic                       full;
    logic                       i_mode      = MODE_PUSH;
    logic signed [SAMPLE_W-1:0] i_sample    = '0;
    logic                       empty;
    logic                       pop         = 1'b0;
    logic signed [STATE_W-1:0]  o_phasor_re;
    logic signed [STATE_W-1:0]  o_phasor_im;
    logic        [POWER_W-1:0]  o_power;
    logic        [STATE_W-1:0]  o_magnitude;
    logic        [STATE_W-1:0]  o_peak;
    logic                       i_cfg_we    = 1'b0;
    logic        [CFG_AW-1:0]   i_cfg_addr  = '0;
    logic        [CFG_W-1:0]    i_cfg_data  = '0;

    // typed expectation that travels with a directed item
    logic        pinned_check  = 1'b0;
    bin_report_t pinned_report = '0;

    // model state and register copies
    logic [STATE_W-1:0] tap_one;
    logic [STATE_W-1:0] tap_two;
    logic [STATE_W-1:0] peak_seen;
    logic [COEFF_W-1:0] reg_coeff;
    logic [TRIG_W-1:0]  reg_cos;
    logic [TRIG_W-1:0]  reg_sin;

    bin_report_t report_q [$];

    int err_count    = 0;
    int stall_cycles = 0;
    int send_idle    = 0;
    int recv_idle    = 0;
    bit hold_req     = 1'b0;

    stim_row_t plan [DIRECTED_ROWS];

    goertzel_bin_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_mode      (i_mode),
        .i_sample    (i_sample),
        .empty       (empty),
        .pop         (pop),
        .o_phasor_re (o_phasor_re),
        .o_phasor_im (o_phasor_im),
        .o_power     (o_power),
        .o_magnitude (o_magnitude),
        .o_peak      (o_peak),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------

    // floor square root, one result bit per trial
    function automatic logic [STATE_W-1:0] floor_root(input logic [63:0] v);
        logic [STATE_W-1:0] root;
        logic [63:0]        trial;
        root = '0;
        for (int b = STATE_W - 1; b >= 0; b--) begin
            trial = {32'd0, root | (32'd1 << b)};
            if (trial * trial <= v) begin
                root = root | (32'd1 << b);
            end
        end
        return root;
    endfunction

    function automatic void set_register(input logic [CFG_AW-1:0] idx,
                                         input logic [CFG_W-1:0] data);
        case (idx)
            CFG_COEFF: reg_coeff = data[COEFF_W-1:0];
            CFG_COS:   reg_cos   = data[TRIG_W-1:0];
            CFG_SIN:   reg_sin   = data[TRIG_W-1:0];
            default:   ;
        endcase
    endfunction

    // one item through the recurrence, then the report from the new state
    function automatic bin_report_t advance_bin(input logic m,
                                                input logic [SAMPLE_W-1:0] x);
        logic signed [63:0] k, c, s, xe, d1, d2, prod, sh, acc;
        logic [STATE_W-1:0] s0, s0_abs;
        bin_report_t        r;
        k = {{(64-COEFF_W){reg_coeff[COEFF_W-1]}}, reg_coeff};
        c = {{(64-TRIG_W){reg_cos[TRIG_W-1]}}, reg_cos};
        s = {{(64-TRIG_W){reg_sin[TRIG_W-1]}}, reg_sin};
        if (m == MODE_CLEAR) begin
            tap_one   = '0;
            tap_two   = '0;
            peak_seen = '0;
        end else begin
            xe   = {{(64-SAMPLE_W){x[SAMPLE_W-1]}}, x};
            d1   = {{32{tap_one[STATE_W-1]}}, tap_one};
            d2   = {{32{tap_two[STATE_W-1]}}, tap_two};
            prod = k * d1;
            sh   = prod >>> COEFF_FRAC_BITS;
            acc  = xe + sh - d2;
            s0   = acc[STATE_W-1:0];
            tap_two = tap_one;
            tap_one = s0;
            s0_abs  = s0[STATE_W-1] ? (32'd0 - s0) : s0;
            if (s0_abs > peak_seen) begin
                peak_seen = s0_abs;
            end
        end

        d1 = {{32{tap_one[STATE_W-1]}}, tap_one};
        d2 = {{32{tap_two[STATE_W-1]}}, tap_two};

        // phasor
        prod = c * d2;
        sh   = prod >>> TRIG_FRAC_BITS;
        acc  = d1 - sh;
        r.re = acc[STATE_W-1:0];
        prod = s * d2;
        sh   = prod >>> TRIG_FRAC_BITS;
        r.im = sh[STATE_W-1:0];

        // power, wrapped to 64 bits, negative clipped to zero
        prod = k * d1;
        prod = prod * d2;
        sh   = prod >>> COEFF_FRAC_BITS;
        acc  = d1 * d1 + d2 * d2 - sh;
        if (acc[63]) begin
            acc = '0;
        end
        r.power = acc[POWER_W-1:0];
        r.mag   = floor_root(acc);
        r.peak  = peak_seen;
        return r;
    endfunction

    // model tracks every transfer as sampled at the edge
    always @(posedge i_clk) begin : predict
        bin_report_t nxt;
        if (!i_rst_n) begin
            tap_one   = '0;
            tap_two   = '0;
            peak_seen = '0;
            reg_coeff = '0;
            reg_cos   = '0;
            reg_sin   = '0;
        end else begin
            if (i_cfg_we) begin
                set_register(i_cfg_addr, i_cfg_data);
            end
            if (push && !full) begin
                nxt = advance_bin(i_mode, i_sample);
                report_q.push_back(pinned_check ? pinned_report : nxt);
            end
        end
    end

    // ------------------------------------------------------------------
    // result check
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : compare
        bin_report_t want;
        if (i_rst_n && pop && !empty) begin
            if (report_q.size() == 0) begin
                $error("result transfer with no item pending");
                err_count++;
            end else begin
                want = report_q.pop_front();
                check_field("phasor_re", 64'(unsigned'(want.re)),
                            64'(unsigned'(o_phasor_re)));
                check_field("phasor_im", 64'(unsigned'(want.im)),
                            64'(unsigned'(o_phasor_im)));
                check_field("power", 64'(want.power), 64'(o_power));
                check_field("magnitude", 64'(want.mag), 64'(o_magnitude));
                check_field("peak", 64'(want.peak), 64'(o_peak));
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random pop, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pop <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // offer one item and hold it until the transfer
    task automatic send_item(input logic m, input logic [SAMPLE_W-1:0] x,
                             input logic pin = 1'b0, input bin_report_t want = '0);
        while ($urandom_range(99) < send_idle) begin
            push     <= 1'b0;
            i_mode   <= 1'($urandom);
            i_sample <= SAMPLE_W'($urandom);
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_mode        <= m;
        i_sample      <= x;
        pinned_check  <= pin;
        pinned_report <= want;
        do @(posedge i_clk); while (full);
    endtask

    // stop offering and let every pending result come back
    task automatic wait_idle();
        push <= 1'b0;
        do @(posedge i_clk); while (report_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_trig();
        case ($urandom_range(3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // new bin setting: extremes, in-range values and raw register bits
    task automatic program_setting();
        logic [CFG_W-1:0] cf;
        case ($urandom_range(5))
            0:       cf = 16'h1000;
            1:       cf = 16'hF000;
            2:       cf = 16'h0000;
            3:       cf = CFG_W'($urandom);
            default: cf = CFG_W'(int'($urandom_range(8192)) - 4096);
        endcase
        if ($urandom_range(3) == 0) begin
            write_reg(CFG_UNUSED, CFG_W'($urandom));
        end
        write_reg(CFG_COEFF, cf);
        write_reg(CFG_COS, pick_trig());
        write_reg(CFG_SIN, pick_trig());
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return SAMPLE_W'(int'($urandom_range(32)) - 16);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // true when speed u still lets the ramp stop within distance p
    function automatic bit can_stop(input longint u, input longint p);
        longint q;
        q = u / RAMP_DECEL;
        return (u + q * u - RAMP_DECEL * q * (q + 1) / 2) <= p;
    endfunction

    // with coeff 2.0 the sample sets the change of slope: accelerate, coast
    // and brake so that s0 lands exactly on the most negative value
    task automatic ramp_to_floor();
        longint s1, s2, p, v, a, lo, hi, mid;
        int     steps;
        wait_idle();
        write_reg(CFG_COEFF, 16'h1000);
        write_reg(CFG_COS, pick_trig());
        write_reg(CFG_SIN, pick_trig());
        send_item(MODE_CLEAR, SAMPLE_W'($urandom));
        s1 = 0;
        s2 = 0;
        steps = 0;
        while (s1 != S0_FLOOR && steps < RAMP_STEPS) begin
            p  = s1 - S0_FLOOR;
            v  = s2 - s1;
            lo = 0;
            hi = p;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (can_stop(mid, p)) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            a = lo - v;
            if (a > RAMP_ACCEL) begin
                a = RAMP_ACCEL;
            end
            if (a < -RAMP_DECEL) begin
                a = -RAMP_DECEL;
            end
            send_item(MODE_PUSH, SAMPLE_W'(-a));
            s2 = s1;
            s1 = s1 - v - a;
            steps++;
        end
        // a few more pushes past the floor, wrapping the state
        repeat (4) send_item(MODE_PUSH, pick_sample());
    endtask

    // random bursts: each opens with a clear, with a stray clear now and then
    task automatic run_phase(input int s_pct, input int r_pct, input int budget,
                             input bit squeeze);
        int   done;
        int   burst;
        logic m;
        send_idle = s_pct;
        recv_idle = r_pct;
        done = 0;
        while (done < budget) begin
            wait_idle();
            program_setting();
            if (squeeze) begin
                hold_req = 1'b1;
                squeeze  = 1'b0;
            end
            repeat (4) begin
                burst = ($urandom_range(9) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(2, 30);
                send_item(MODE_CLEAR, SAMPLE_W'($urandom));
                for (int k = 0; k < burst; k++) begin
                    m = ($urandom_range(49) == 0) ? MODE_CLEAR : MODE_PUSH;
                    send_item(m, pick_sample());
                end
                done += burst + 1;
            end
        end
    endtask

    // directed rows; pinned values hold only right after reset or a clear
    initial begin
        plan = '{
            '{ROW_ITEM, CFG_COEFF, MODE_CLEAR, 16'h7FFF, 1'b1, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h7FFF, 1'b1,
              '{32'sd32767, 32'sd0, 63'd1073676289, 32'd32767, 32'd32767}},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h0000, 1'b1,
              '{32'sd0, 32'sd0, 63'd1073676289, 32'd32767, 32'd32767}},
            '{ROW_ITEM, CFG_COEFF, MODE_CLEAR, 16'h8000, 1'b1, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h8000, 1'b1,
              '{-32'sd32768, 32'sd0, 63'd1073741824, 32'd32768, 32'd32768}},
            // coeff 2.0, trig extremes
            '{ROW_CFG,  CFG_COEFF, MODE_PUSH,  16'h1000, 1'b0, '0},
            '{ROW_CFG,  CFG_COS,   MODE_PUSH,  16'h7FFF, 1'b0, '0},
            '{ROW_CFG,  CFG_SIN,   MODE_PUSH,  16'h8000, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h8000, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h8000, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h7FFF, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h0000, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_CLEAR, 16'h0000, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h0001, 1'b0, '0},
            // coeff -2.0, trig extremes swapped
            '{ROW_CFG,  CFG_COEFF, MODE_PUSH,  16'hF000, 1'b0, '0},
            '{ROW_CFG,  CFG_COS,   MODE_PUSH,  16'h8000, 1'b0, '0},
            '{ROW_CFG,  CFG_SIN,   MODE_PUSH,  16'h7FFF, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h7FFF, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h7FFF, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h8000, 1'b0, '0},
            // write to an unused index, then coeff outside its range
            '{ROW_CFG,  CFG_UNUSED, MODE_PUSH, 16'hFFFF, 1'b0, '0},
            '{ROW_CFG,  CFG_COEFF, MODE_PUSH,  16'h2000, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h7FFF, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h8000, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h7FFF, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h8000, 1'b0, '0},
            // upper data bits dropped: coeff -1/2048, shifts round down
            '{ROW_CFG,  CFG_COEFF, MODE_PUSH,  16'hFFFF, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'hFFFF, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'h5555, 1'b0, '0},
            '{ROW_ITEM, CFG_COEFF, MODE_PUSH,  16'hAAAA, 1'b0, '0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (plan[r].kind == ROW_CFG) begin
                wait_idle();
                write_reg(plan[r].addr, plan[r].value);
            end else begin
                send_item(plan[r].mode, plan[r].value, plan[r].pinned, plan[r].want);
            end
        end

        ramp_to_floor();

        run_phase(36, 82, PHASE_ITEMS, 1'b0);
        run_phase(82, 36, PHASE_ITEMS, 1'b0);
        run_phase(0, 0, PHASE_ITEMS, 1'b1);

        wait_idle();
        repeat (2 * SETTLE) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/gbt_pkg.sv
design/gbt_queue.sv
design/gbt_front.sv
design/gbt_back.sv
design/goertzel_bin_tracker.sv
dv/tb_top.sv
